// File: design/assert_macros.svh
// Assertion helpers for the frame deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// Checked only while out of reset.
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

// File: design/wsdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsdf_pkg;

    // length accumulator width (parameter default)
    localparam int LENGTH_BITS_DEF = 64;

    // config port
    localparam int        CFG_ADDR_BITS   = 4;
    localparam int        CFG_DATA_BITS   = 64;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_MAX_LEN = 4'h0;
    localparam logic [62:0] MAX_LEN_RESET = 63'h400_0000;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic ERR_RESERVED  = 1'b0;
    localparam logic ERR_TOO_LARGE = 1'b1;

    // parser phases
    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    // 7-bit length escapes
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic        fin_bit;
        logic [3:0]  frame_opcode;
        logic        mask_present;
        logic [62:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic        error_code;
    } result_t;

endpackage
`default_nettype wire

// File: design/websocket_frame_deframer_unmasker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// s_ (in)   | s_valid / s_ready  | s_rx_byte[7:0]
// m_ (out)  | m_valid / m_ready  | kind, fin, opcode, mask, length, byte,
//           |                    | last, error_code
// APB cfg   | psel/penable/pready| max_payload_length at 0x0 (64-bit data)
//
// One byte per cycle sustained unless a result waits on m_ready; each byte is
// registered in the input register, then the parser and limit compare run
// combinationally into the output register.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the first header byte; the limit reloads to 64 MiB.
// A stalled m_ready holds the result; bytes that give no result keep moving.
`include "assert_macros.svh"
module websocket_frame_deframer_unmasker_top #(
    parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // request input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_rx_byte,
    // results
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_kind,
    output logic                                    m_fin_bit,
    output logic [3:0]                              m_frame_opcode,
    output logic                                    m_mask_present,
    output logic [62:0]                             m_payload_length,
    output logic [7:0]                              m_payload_byte,
    output logic                                    m_last_of_frame,
    output logic                                    m_error_code,
    // config
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wsdf_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [wsdf_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [wsdf_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                    pready
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              fire;
    logic              res_has;
    logic              out_free;
    wsdf_pkg::result_t res;
    logic [62:0]       max_len_reg;
    logic              cfg_hit;

    // config register
    assign pready  = 1'b1;
    assign cfg_hit = (paddr == wsdf_pkg::ADDR_MAX_LEN);
    assign prdata  = cfg_hit ? {1'b0, max_len_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= wsdf_pkg::MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            max_len_reg <= pwdata[62:0];
        end
    end

    // byte advances unless it has a result and the output slot is full
    assign fire = in_valid && (!res_has || out_free);

    wsdf_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .take      (fire),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    wsdf_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .rx_byte (in_byte),
        .max_len (max_len_reg),
        .res_has (res_has),
        .res     (res)
    );

    wsdf_out_stage u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (fire && res_has),
        .res              (res),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fin_bit        (m_fin_bit),
        .m_frame_opcode   (m_frame_opcode),
        .m_mask_present   (m_mask_present),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_frame  (m_last_of_frame),
        .m_error_code     (m_error_code)
    );

    // checks
    `ASSERT_ALWAYS(a_rst_empties_out, (!aresetn |=> !m_valid), "result valid after reset")
    `ASSERT_RUN(a_ready_when_empty, (!in_valid |-> s_ready), "input stalled while empty")
    `ASSERT_RUN(a_byte_only_payload, ((m_valid && (m_kind != wsdf_pkg::KIND_PAYLOAD)) |-> (m_payload_byte == 8'd0)), "payload byte on non-payload result")
    `ASSERT_RUN(a_err_not_last, ((m_valid && (m_kind == wsdf_pkg::KIND_ERROR)) |-> (!m_last_of_frame && (m_payload_byte == 8'd0))), "error flagged last")

endmodule
`default_nettype wire

// File: design/wsdf_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module wsdf_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       take,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // room when empty or when the held byte moves on this cycle
    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule
`default_nettype wire

// File: design/wsdf_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module wsdf_parser #(
    parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fire,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [62:0] max_len,
    output logic             res_has,
    output wsdf_pkg::result_t res
);

    logic [2:0]             phase_reg,  phase_next;
    logic [7:0]             fhb_reg,    fhb_next;
    logic                   masked_reg, masked_next;
    logic [LENGTH_BITS-1:0] acc_reg,    acc_next;
    logic [2:0]             cnt_reg,    cnt_next;
    logic [31:0]            key_reg,    key_next;
    logic [62:0]            remain_reg, remain_next;
    logic [1:0]             midx_reg,   midx_next;

    logic        len_done;
    logic        hdr_done;
    logic [63:0] acc64;
    logic [7:0]  key_byte;
    logic        pay_last;

    // key byte for this payload position, first key byte at index 0
    assign key_byte = masked_reg ? 8'(key_reg >> {~midx_reg, 3'b000}) : 8'd0;
    assign pay_last = (remain_reg == 63'd1);

    always_comb begin
        phase_next  = phase_reg;
        fhb_next    = fhb_reg;
        masked_next = masked_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        midx_next   = midx_reg;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        res_has     = 1'b0;
        res         = '0;

        case (phase_reg)
            wsdf_pkg::PH_HDR2: begin
                masked_next = rx_byte[7];
                if (fhb_reg[6:4] != 3'd0) begin
                    phase_next     = wsdf_pkg::PH_HDR1;
                    res_has        = 1'b1;
                    res.kind       = wsdf_pkg::KIND_ERROR;
                    res.error_code = wsdf_pkg::ERR_RESERVED;
                end else begin
                    acc_next = '0;
                    if (rx_byte[6:0] == wsdf_pkg::LEN_CODE_16) begin
                        phase_next = wsdf_pkg::PH_EXT;
                        cnt_next   = 3'd1;
                    end else if (rx_byte[6:0] == wsdf_pkg::LEN_CODE_64) begin
                        phase_next = wsdf_pkg::PH_EXT;
                        cnt_next   = 3'd7;
                    end else begin
                        acc_next = LENGTH_BITS'(rx_byte[6:0]);
                        len_done = 1'b1;
                    end
                end
            end
            wsdf_pkg::PH_EXT: begin
                // big-endian shift in, saturating once a set bit would fall off
                if (acc_reg[LENGTH_BITS-1 -: 8] != 8'd0) begin
                    acc_next = '1;
                end else begin
                    acc_next = {acc_reg[LENGTH_BITS-9:0], rx_byte};
                end
                if (cnt_reg != 3'd0) begin
                    cnt_next = cnt_reg - 3'd1;
                end else begin
                    len_done = 1'b1;
                end
            end
            wsdf_pkg::PH_KEY: begin
                key_next = {key_reg[23:0], rx_byte};
                if (cnt_reg != 3'd0) begin
                    cnt_next = cnt_reg - 3'd1;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            wsdf_pkg::PH_PAY: begin
                midx_next        = midx_reg + 2'd1;
                remain_next      = remain_reg - 63'd1;
                res_has          = 1'b1;
                res.kind         = wsdf_pkg::KIND_PAYLOAD;
                res.payload_byte = rx_byte ^ key_byte;
                res.last_of_frame = pay_last;
                if (pay_last) begin
                    phase_next = wsdf_pkg::PH_HDR1;
                end
            end
            default: begin
                fhb_next   = rx_byte;
                phase_next = wsdf_pkg::PH_HDR2;
            end
        endcase

        acc64 = 64'(acc_next);

        // length complete: limit check, then key or header
        if (len_done) begin
            key_next = '0;
            if (acc64 > {1'b0, max_len}) begin
                phase_next     = wsdf_pkg::PH_HDR1;
                res_has        = 1'b1;
                res.kind       = wsdf_pkg::KIND_ERROR;
                res.error_code = wsdf_pkg::ERR_TOO_LARGE;
            end else if (masked_next) begin
                phase_next = wsdf_pkg::PH_KEY;
                cnt_next   = 3'd3;
            end else begin
                hdr_done = 1'b1;
            end
        end

        // header complete
        if (hdr_done) begin
            remain_next = acc64[62:0];
            midx_next   = 2'd0;
            res_has     = 1'b1;
            res.kind    = wsdf_pkg::KIND_HEADER;
            if (acc64[62:0] == 63'd0) begin
                phase_next        = wsdf_pkg::PH_HDR1;
                res.last_of_frame = 1'b1;
            end else begin
                phase_next = wsdf_pkg::PH_PAY;
            end
        end

        // fields common to every result
        res.fin_bit        = fhb_reg[7];
        res.frame_opcode   = fhb_reg[3:0];
        res.mask_present   = masked_next;
        res.payload_length = (res.kind == wsdf_pkg::KIND_ERROR &&
                              res.error_code == wsdf_pkg::ERR_RESERVED) ? 63'd0
                                                                        : acc64[62:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsdf_pkg::PH_HDR1;
            fhb_reg    <= '0;
            masked_reg <= 1'b0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            midx_reg   <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            fhb_reg    <= fhb_next;
            masked_reg <= masked_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            midx_reg   <= midx_next;
        end
    end

endmodule
`default_nettype wire

// File: design/wsdf_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module wsdf_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire wsdf_pkg::result_t res,
    output logic                   out_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic                   m_fin_bit,
    output logic [3:0]             m_frame_opcode,
    output logic                   m_mask_present,
    output logic [62:0]            m_payload_length,
    output logic [7:0]             m_payload_byte,
    output logic                   m_last_of_frame,
    output logic                   m_error_code
);

    logic              valid_reg;
    wsdf_pkg::result_t res_reg;

    // slot frees up when empty or being taken this cycle
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && out_free) begin
            res_reg <= res;
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = res_reg.kind;
    assign m_fin_bit        = res_reg.fin_bit;
    assign m_frame_opcode   = res_reg.frame_opcode;
    assign m_mask_present   = res_reg.mask_present;
    assign m_payload_length = res_reg.payload_length;
    assign m_payload_byte   = res_reg.payload_byte;
    assign m_last_of_frame  = res_reg.last_of_frame;
    assign m_error_code     = res_reg.error_code;

endmodule
`default_nettype wire
